// ----- hw/rtl/asbd_pkg.sv -----
// Shared types and constants for the area-sorted block dictionary.
`timescale 1ns / 1ps

package asbd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int IN_ID_W    = 16;
  localparam int IN_SIDE_W  = 8;
  localparam int IN_IDX_W   = 6;
  localparam int HELD_W     = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_INCR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Update strobes broadcast to every cell; at most one is high per cycle.
  typedef struct packed {
    logic ins;
    logic rem;
    logic inc;
  } cmd_t;

endpackage

// ----- hw/rtl/area_sorted_block_dictionary_unit.sv -----
// Top level of the area-sorted block dictionary: input stage, cell chain, output register.
`timescale 1ns / 1ps

// Usage
//   Slave channel s_*: one command item per handshake (insert, remove, read at
//   index, increment usage count). Master channel m_*: exactly one result item
//   per command, in command order.
//   Entries live in a row of CAPACITY cells kept in ascending area order; each
//   insert or remove updates every cell at once, shifting entries to the neighbor cell.
//   An accepted item waits in the command stage, which registers its result on
//   m_tdata as it fires. Throughput: one item per cycle while m_tready stays
//   high; the area product is registered at acceptance and the cell row updates
//   in the next cycle, so back-to-back items see each other's updates.
//   Stall: when a result waits and m_tready is low, the command stage holds and
//   s_tready drops once that stage is occupied; nothing is lost or repeated.
//   Reset: rst (synchronous, active high) empties the table (entry count zero)
//   and drops any item in flight. Slot contents are not cleared; only slots
//   below the entry count are ever read.
module area_sorted_block_dictionary_unit #(
  parameter int CAPACITY  = 64,
  parameter int ID_BITS   = 16,
  parameter int SIDE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // action[1:0], block_id[17:2], block_width[25:18], block_height[33:26],
  // entry_index[39:34]
  input  logic [asbd_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[1:0], found_id[17:2], found_width[25:18], found_height[33:26],
  // found_count[65:34], entries_held[72:66], zero[79:73]
  output logic [asbd_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import asbd_pkg::*;

  localparam int TOT_BITS  = $clog2(CAPACITY + 1);
  localparam int AREA_BITS = 2 * SIDE_BITS;
  localparam int EW        = ID_BITS + 2 * SIDE_BITS + AREA_BITS + COUNT_BITS;
  localparam int W_LO      = ID_BITS;
  localparam int H_LO      = ID_BITS + SIDE_BITS;
  localparam int COUNT_LO  = ID_BITS + 2 * SIDE_BITS + AREA_BITS;

  // Command stage
  logic                  p_valid;
  action_t               p_action;
  logic [ID_BITS-1:0]    p_id;
  logic [SIDE_BITS-1:0]  p_w;
  logic [SIDE_BITS-1:0]  p_h;
  logic [AREA_BITS-1:0]  p_area;
  logic [IN_IDX_W-1:0]   p_idx;

  logic [SIDE_BITS-1:0]  in_w;
  logic [SIDE_BITS-1:0]  in_h;
  logic [AREA_BITS-1:0]  in_area;

  logic [TOT_BITS-1:0]   total;
  logic [TOT_BITS-1:0]   total_next;
  logic                  fire;
  logic                  full;
  logic                  found;
  logic                  in_range;
  cmd_t                  cmd;
  status_t               status_next;
  logic [EW-1:0]         new_ent;
  logic [EW-1:0]         rd_ent;
  logic [EW-1:0]         sel_ent;

  logic [EW-1:0]         ent   [CAPACITY];
  logic                  lt    [CAPACITY];
  logic                  below [CAPACITY+1];
  logic                  above [CAPACITY+1];
  logic [EW-1:0]         rd    [CAPACITY+1];

  assign in_w    = SIDE_BITS'(s_tdata[25:18]);
  assign in_h    = SIDE_BITS'(s_tdata[33:26]);
  assign in_area = in_w * in_h;

  assign fire     = p_valid && (!m_tvalid || m_tready);
  assign s_tready = !p_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      p_valid <= 1'b1;
    end else if (fire) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      p_action <= action_t'(s_tdata[1:0]);
      p_id     <= ID_BITS'(s_tdata[17:2]);
      p_w      <= in_w;
      p_h      <= in_h;
      p_area   <= in_area;
      p_idx    <= s_tdata[39:34];
    end
  end

  // Cell row
  assign new_ent = {{COUNT_BITS{1'b0}}, p_area, p_h, p_w, p_id};
  assign below[0]        = 1'b0;
  assign above[CAPACITY] = 1'b0;
  assign rd[0]           = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] prev_ent;
    logic          prev_lt;
    logic [EW-1:0] next_ent;

    if (i == 0) begin : g_first
      assign prev_ent = new_ent;
      assign prev_lt  = 1'b1;
    end else begin : g_mid
      assign prev_ent = ent[i-1];
      assign prev_lt  = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_ent = ent[i];
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end

    asbd_cell #(
      .POS       (i),
      .EW        (EW),
      .ID_BITS   (ID_BITS),
      .SIDE_BITS (SIDE_BITS),
      .TOT_BITS  (TOT_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_ent   (new_ent),
      .total     (total),
      .rd_index  (p_idx),
      .prev_ent  (prev_ent),
      .prev_lt   (prev_lt),
      .next_ent  (next_ent),
      .below_in  (below[i]),
      .above_in  (above[i+1]),
      .rd_in     (rd[i]),
      .ent       (ent[i]),
      .lt        (lt[i]),
      .below_out (below[i+1]),
      .above_out (above[i]),
      .rd_out    (rd[i+1])
    );
  end

  assign rd_ent   = rd[CAPACITY];
  assign found    = above[0];
  assign full     = total == TOT_BITS'(CAPACITY);
  assign in_range = 32'(p_idx) < 32'(total);

  always_comb begin
    cmd         = '0;
    status_next = ST_OK;
    total_next  = total;
    sel_ent     = '0;
    case (p_action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.ins    = fire;
          total_next = total + TOT_BITS'(1);
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          cmd.rem    = fire;
          total_next = total - TOT_BITS'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      ACT_READ: begin
        if (in_range) begin
          sel_ent = rd_ent;
        end else begin
          status_next = ST_RANGE;
        end
      end
      ACT_INCR: begin
        cmd.inc = fire;
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (fire) begin
      total <= total_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {7'd0,
                  HELD_W'(total_next),
                  sel_ent[EW-1:COUNT_LO],
                  IN_SIDE_W'(sel_ent[H_LO+SIDE_BITS-1:H_LO]),
                  IN_SIDE_W'(sel_ent[W_LO+SIDE_BITS-1:W_LO]),
                  IN_ID_W'(sel_ent[ID_BITS-1:0]),
                  status_next};
    end
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> total == $past(total) + TOT_BITS'(1))
    else $error("insert did not add one entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    fire && (status_next == ST_FULL) |-> total == TOT_BITS'(CAPACITY))
    else $error("full reported below capacity");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> p_valid && m_tvalid && !m_tready)
    else $error("input stalled without an output stall");

endmodule

// ----- hw/rtl/asbd_cell.sv -----
// One dictionary slot: holds an entry and shifts, takes or bumps it on command.
`timescale 1ns / 1ps

module asbd_cell #(
  parameter int POS       = 0,
  parameter int EW        = 80,
  parameter int ID_BITS   = 16,
  parameter int SIDE_BITS = 8,
  parameter int TOT_BITS  = 7
) (
  input  logic                 clk,
  input  asbd_pkg::cmd_t       cmd,
  input  logic [EW-1:0]        new_ent,
  input  logic [TOT_BITS-1:0]  total,
  input  logic [5:0]           rd_index,
  input  logic [EW-1:0]        prev_ent,
  input  logic                 prev_lt,
  input  logic [EW-1:0]        next_ent,
  input  logic                 below_in,
  input  logic                 above_in,
  input  logic [EW-1:0]        rd_in,
  output logic [EW-1:0]        ent,
  output logic                 lt,
  output logic                 below_out,
  output logic                 above_out,
  output logic [EW-1:0]        rd_out
);
  import asbd_pkg::*;

  localparam int AREA_BITS = 2 * SIDE_BITS;
  localparam int AREA_LO   = ID_BITS + 2 * SIDE_BITS;
  localparam int COUNT_LO  = AREA_LO + AREA_BITS;

  logic                  occ;
  logic                  match;
  logic [ID_BITS-1:0]    cur_id;
  logic [ID_BITS-1:0]    key_id;
  logic [AREA_BITS-1:0]  cur_area;
  logic [AREA_BITS-1:0]  key_area;
  logic [COUNT_BITS-1:0] cur_count;

  assign occ       = total > TOT_BITS'(POS);
  assign cur_id    = ent[ID_BITS-1:0];
  assign key_id    = new_ent[ID_BITS-1:0];
  assign cur_area  = ent[COUNT_LO-1:AREA_LO];
  assign key_area  = new_ent[COUNT_LO-1:AREA_LO];
  assign cur_count = ent[EW-1:COUNT_LO];

  assign match     = occ && (cur_id == key_id);
  assign lt        = occ && (cur_area < key_area);
  assign below_out = below_in | match;
  assign above_out = above_in | match;
  assign rd_out    = (32'(rd_index) == POS) ? ent : rd_in;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      // Cells at or above the insertion point move up by one.
      if (!lt) begin
        ent <= prev_lt ? new_ent : prev_ent;
      end
    end else if (cmd.rem) begin
      // The last matching cell and all above it pull from the next one.
      if (!above_in) begin
        ent <= next_ent;
      end
    end else if (cmd.inc) begin
      if (match && !below_in && (cur_count != {COUNT_BITS{1'b1}})) begin
        ent[EW-1:COUNT_LO] <= cur_count + COUNT_BITS'(1);
      end
    end
  end

endmodule
